### src/nsc_pkg.sv
// Shared types, constants and helpers for the NMEA sentence checksum framer.
// No dependencies; every other file in src uses it by scoped names.
package nsc_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TAG_W  = 40;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned NIB_W  = 4;

  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [TAG_W-1:0]  TAG_RESET = 40'h4750474741;  // "GPGGA"

  // Header characters after '$' and the position of the first one
  localparam logic [CNT_W-1:0] HDR_FIRST = 7'd1;
  localparam logic [CNT_W-1:0] HDR_LAST  = 7'd5;
  localparam logic [CNT_W-1:0] HDR_FULL  = 7'd6;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_COLLECT = 2'd1,
    PH_HEX_HI  = 2'd2,
    PH_HEX_LO  = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t            phase;
    logic [BYTE_W-1:0] running_xor;
    logic [CNT_W-1:0]  char_count;
    logic              header_match;
    logic [NIB_W-1:0]  high_nibble;
    logic              hex_valid;
  } frame_state_t;

  typedef struct packed {
    logic              sentence_ok;
    logic              checksum_ok;
    logic              header_ok;
    logic [BYTE_W-1:0] computed_sum;
    logic [BYTE_W-1:0] received_sum;
    logic [CNT_W-1:0]  sentence_length;
  } verdict_t;

  typedef struct packed {
    logic             ok;
    logic [NIB_W-1:0] value;
  } hex_digit_t;

  // Decode one hex character, upper or lower case; non-hex gives value 0
  function automatic hex_digit_t hex_decode(input logic [BYTE_W-1:0] c);
    hex_digit_t d;
    logic [BYTE_W-1:0] diff;
    d = '{ok: 1'b0, value: '0};
    diff = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      diff = c - 8'h30;
      d.ok = 1'b1;
      d.value = diff[NIB_W-1:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      diff = c - 8'h37;
      d.ok = 1'b1;
      d.value = diff[NIB_W-1:0];
    end else if (c >= 8'h61 && c <= 8'h66) begin
      diff = c - 8'h57;
      d.ok = 1'b1;
      d.value = diff[NIB_W-1:0];
    end
    return d;
  endfunction

endpackage

### src/nsc_if.sv
// Handshake channel interfaces: received bytes, verdicts and tag writes.
// Depends on nsc_pkg for field widths.
interface nsc_in_if;
  logic                           valid;
  logic                           ready;
  logic [nsc_pkg::BYTE_W-1:0]     rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsc_out_if;
  logic                           valid;
  logic                           ready;
  logic                           sentence_ok;
  logic                           checksum_ok;
  logic                           header_ok;
  logic [nsc_pkg::BYTE_W-1:0]     computed_sum;
  logic [nsc_pkg::BYTE_W-1:0]     received_sum;
  logic [nsc_pkg::CNT_W-1:0]      sentence_length;
  modport source (output valid, output sentence_ok, output checksum_ok, output header_ok,
                  output computed_sum, output received_sum, output sentence_length,
                  input ready);
  modport sink   (input valid, input sentence_ok, input checksum_ok, input header_ok,
                  input computed_sum, input received_sum, input sentence_length,
                  output ready);
endinterface

interface nsc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [nsc_pkg::TAG_W-1:0]      header_tag;
  modport source (output valid, output header_tag, input ready);
  modport sink   (input valid, input header_tag, output ready);
endinterface

### src/nsc_step.sv
// Per-byte framing logic: next framer state and the verdict for one byte.
// Depends on nsc_pkg.
module nsc_step #(
  parameter int unsigned MAX_SENTENCE = 125
) (
  input  nsc_pkg::frame_state_t        cur,
  input  logic [nsc_pkg::BYTE_W-1:0]   rx_byte,
  input  logic [nsc_pkg::TAG_W-1:0]    header_tag,
  output nsc_pkg::frame_state_t        nxt,
  output logic                         emit,
  output nsc_pkg::verdict_t            verdict
);

  localparam logic [nsc_pkg::CNT_W-1:0] CAP = nsc_pkg::CNT_W'(MAX_SENTENCE);

  logic [nsc_pkg::BYTE_W-1:0] want;
  logic [nsc_pkg::CNT_W-1:0]  cnt_inc;
  nsc_pkg::hex_digit_t        digit;
  logic [nsc_pkg::BYTE_W-1:0] recv;
  logic                       ck;
  logic                       hd;

  // Pick the tag character for this header position
  always_comb begin
    case (cur.char_count)
      7'd1:    want = header_tag[39:32];
      7'd2:    want = header_tag[31:24];
      7'd3:    want = header_tag[23:16];
      7'd4:    want = header_tag[15:8];
      7'd5:    want = header_tag[7:0];
      default: want = '0;
    endcase
  end

  assign cnt_inc = cur.char_count + 7'd1;
  assign digit   = nsc_pkg::hex_decode(rx_byte);
  assign recv    = {cur.high_nibble, digit.value};
  assign ck      = cur.hex_valid && digit.ok && (recv == cur.running_xor);
  assign hd      = cur.header_match && (cur.char_count >= nsc_pkg::HDR_FULL);

  // Build the verdict, only used on the second checksum character
  always_comb begin
    verdict.sentence_ok     = ck && hd;
    verdict.checksum_ok     = ck;
    verdict.header_ok       = hd;
    verdict.computed_sum    = cur.running_xor;
    verdict.received_sum    = recv;
    verdict.sentence_length = cur.char_count;
  end

  // Advance the framer by one byte
  always_comb begin
    nxt  = cur;
    emit = 1'b0;
    case (cur.phase)
      nsc_pkg::PH_HUNT: begin
        if (rx_byte == nsc_pkg::CH_DOLLAR) begin
          nxt.phase        = nsc_pkg::PH_COLLECT;
          nxt.char_count   = nsc_pkg::HDR_FIRST;
          nxt.running_xor  = '0;
          nxt.header_match = 1'b1;
          nxt.high_nibble  = '0;
          nxt.hex_valid    = 1'b1;
        end
      end
      nsc_pkg::PH_COLLECT: begin
        if (cur.char_count >= nsc_pkg::HDR_FIRST && cur.char_count <= nsc_pkg::HDR_LAST &&
            rx_byte != want) begin
          nxt.header_match = 1'b0;
        end
        nxt.char_count = cnt_inc;
        if (rx_byte != nsc_pkg::CH_STAR) begin
          nxt.running_xor = cur.running_xor ^ rx_byte;
        end
        if (rx_byte == nsc_pkg::CH_STAR || cnt_inc >= CAP) begin
          nxt.phase = nsc_pkg::PH_HEX_HI;
        end
      end
      nsc_pkg::PH_HEX_HI: begin
        nxt.high_nibble = digit.value;
        nxt.hex_valid   = digit.ok;
        nxt.phase       = nsc_pkg::PH_HEX_LO;
      end
      nsc_pkg::PH_HEX_LO: begin
        emit      = 1'b1;
        nxt.phase = nsc_pkg::PH_HUNT;
      end
      default: begin
        nxt.phase = nsc_pkg::PH_HUNT;
      end
    endcase
  end

endmodule

### src/nmea_sentence_checksum_framer_core.sv
// Top level of the NMEA sentence checksum framer: input register, framer
// state, verdict register and tag register. Depends on nsc_pkg, nsc_if, nsc_step.
//
//   channel  | dir | payload                                   | handshake
//   ---------+-----+-------------------------------------------+-------------
//   in_ch    | in  | rx_byte                                   | valid/ready
//   out_ch   | out | sentence_ok checksum_ok header_ok         | valid/ready
//            |     | computed_sum received_sum sentence_length |
//   cfg_ch   | in  | header_tag                                | valid/ready
//
// One byte per cycle unless a stalled verdict holds the input: a byte is registered,
// then stepped through the framer into the verdict register; the verdict is offered
// from that register once the second checksum byte has been stepped.
// A stalled verdict blocks only the byte that would make the next verdict;
// other bytes keep flowing. cfg_ch is always ready.
// Synchronous active-low reset: hunting for '$', tag back to "GPGGA".
module nmea_sentence_checksum_framer_core #(
  parameter int unsigned MAX_SENTENCE = 125
) (
  input  logic              clk,
  input  logic              rst_n,
  nsc_in_if.sink            in_ch,
  nsc_out_if.source         out_ch,
  nsc_cfg_if.sink           cfg_ch
);

  logic                       in_v_r;
  logic [nsc_pkg::BYTE_W-1:0] in_byte_r;
  logic [nsc_pkg::TAG_W-1:0]  tag_r;
  nsc_pkg::frame_state_t      st_r;
  nsc_pkg::frame_state_t      st_nxt;
  logic                       out_v_r;
  nsc_pkg::verdict_t          out_res_r;
  nsc_pkg::verdict_t          res_nxt;
  logic                       emit;
  logic                       advance;
  logic                       in_ready;

  nsc_step #(.MAX_SENTENCE(MAX_SENTENCE)) u_step (
    .cur        (st_r),
    .rx_byte    (in_byte_r),
    .header_tag (tag_r),
    .nxt        (st_nxt),
    .emit       (emit),
    .verdict    (res_nxt)
  );

  // Step the held byte unless its verdict has nowhere to go
  assign advance  = in_v_r && (!emit || !out_v_r || out_ch.ready);
  assign in_ready = !in_v_r || advance;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid           = out_v_r;
  assign out_ch.sentence_ok     = out_res_r.sentence_ok;
  assign out_ch.checksum_ok     = out_res_r.checksum_ok;
  assign out_ch.header_ok       = out_res_r.header_ok;
  assign out_ch.computed_sum    = out_res_r.computed_sum;
  assign out_ch.received_sum    = out_res_r.received_sum;
  assign out_ch.sentence_length = out_res_r.sentence_length;

  // Hold the configured tag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= nsc_pkg::TAG_RESET;
    end else if (cfg_ch.valid) begin
      tag_r <= cfg_ch.header_tag;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  // Framer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase        <= nsc_pkg::PH_HUNT;
      st_r.running_xor  <= '0;
      st_r.char_count   <= '0;
      st_r.header_match <= 1'b1;
      st_r.high_nibble  <= '0;
      st_r.hex_valid    <= 1'b1;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Verdict register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance && emit) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_res_r <= res_nxt;
    end
  end

endmodule

### sim/tb_nmea_sentence_checksum_framer_core.sv
// Testbench for nmea_sentence_checksum_framer_core: a directed byte table, then random
// sentences under several header tags; verdicts checked against the table or a framer model.
// Depends on src/nsc_pkg.sv, src/nsc_if.sv and the core RTL.
module tb_nmea_sentence_checksum_framer_core;

  localparam int unsigned MAX_LEN        = 125;
  localparam int unsigned PHASE_ITEMS    = 200;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam logic [nsc_pkg::TAG_W-1:0] TAG_GPRMC = 40'h4750524D43;

  typedef enum logic [1:0] {SEQ_NOISE, SEQ_BROKEN, SEQ_CAP, SEQ_WELL} seq_kind_t;
  typedef enum logic [1:0] {CK_GOOD, CK_WRONG, CK_JUNK} ck_kind_t;

  typedef struct packed {
    logic [nsc_pkg::BYTE_W-1:0] rx;
    logic                       typed;
    nsc_pkg::verdict_t          want;
  } stim_row_t;

  localparam nsc_pkg::verdict_t NO_VERDICT = '0;

  // Directed bytes; typed verdicts hold for the reset tag "GPGGA"
  localparam stim_row_t DIRECTED [0:23] = '{
    '{8'h00, 1'b0, NO_VERDICT},                                  // dropped while hunting
    '{8'hFF, 1'b0, NO_VERDICT},
    '{8'h24, 1'b0, NO_VERDICT},                                  // shortest sentence "$*00"
    '{8'h2A, 1'b0, NO_VERDICT},
    '{8'h30, 1'b0, NO_VERDICT},
    '{8'h30, 1'b1, '{1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 7'd2}},
    '{8'h24, 1'b0, NO_VERDICT},                                  // "$GPGGA*56"
    '{8'h47, 1'b0, NO_VERDICT},
    '{8'h50, 1'b0, NO_VERDICT},
    '{8'h47, 1'b0, NO_VERDICT},
    '{8'h47, 1'b0, NO_VERDICT},
    '{8'h41, 1'b0, NO_VERDICT},
    '{8'h2A, 1'b0, NO_VERDICT},
    '{8'h35, 1'b0, NO_VERDICT},
    '{8'h36, 1'b1, '{1'b1, 1'b1, 1'b1, 8'h56, 8'h56, 7'd7}},
    '{8'h24, 1'b0, NO_VERDICT},                                  // non-hex then lower case
    '{8'h2A, 1'b0, NO_VERDICT},
    '{8'h67, 1'b0, NO_VERDICT},
    '{8'h66, 1'b1, '{1'b0, 1'b0, 1'b0, 8'h00, 8'h0F, 7'd2}},
    '{8'h24, 1'b0, NO_VERDICT},                                  // dollar inside a sentence
    '{8'h24, 1'b0, NO_VERDICT},
    '{8'h2A, 1'b0, NO_VERDICT},
    '{8'h32, 1'b0, NO_VERDICT},
    '{8'h34, 1'b1, '{1'b0, 1'b1, 1'b0, 8'h24, 8'h24, 7'd3}}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  nsc_in_if  in_ch();
  nsc_out_if out_ch();
  nsc_cfg_if cfg_ch();

  nmea_sentence_checksum_framer_core #(
    .MAX_SENTENCE(MAX_LEN)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Framer model state and its copy of the tag register
  nsc_pkg::phase_t            fr_phase     = nsc_pkg::PH_HUNT;
  logic [nsc_pkg::BYTE_W-1:0] fr_sum       = 8'h00;
  logic [nsc_pkg::CNT_W-1:0]  fr_count     = 7'd0;
  logic                       fr_hdr_match = 1'b1;
  logic [nsc_pkg::NIB_W-1:0]  fr_hi_nib    = 4'h0;
  logic                       fr_hi_ok     = 1'b1;
  logic [nsc_pkg::TAG_W-1:0]  tag_now      = nsc_pkg::TAG_RESET;

  nsc_pkg::verdict_t          pending_verdicts [$];
  logic [nsc_pkg::BYTE_W-1:0] rx_plan [$];
  int unsigned                mismatches = 0;
  int unsigned                idle_cycles = 0;
  logic                       no_idle = 1'b0;
  logic                       hold_req = 1'b0;

  // {ok, value} of one checksum character
  function automatic logic [4:0] nibble_of(input logic [nsc_pkg::BYTE_W-1:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
    return 5'b0;
  endfunction

  function automatic logic [nsc_pkg::BYTE_W-1:0] hex_char(input logic [nsc_pkg::NIB_W-1:0] n,
                                                          input logic lower);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    return (lower ? 8'h61 : 8'h41) + {4'h0, n} - 8'd10;
  endfunction

  // Advance the framer model by one byte; return 1 with the verdict it emits
  function automatic logic predict_verdict(input logic [nsc_pkg::BYTE_W-1:0] b,
                                           output nsc_pkg::verdict_t v);
    logic [4:0]                 d;
    logic [nsc_pkg::BYTE_W-1:0] want, recv;
    logic                       ck, hd, emit;
    v = '0;
    emit = 1'b0;
    d = nibble_of(b);
    case (fr_phase)
      nsc_pkg::PH_HUNT: begin
        if (b == nsc_pkg::CH_DOLLAR) begin
          fr_phase     = nsc_pkg::PH_COLLECT;
          fr_count     = 7'd1;
          fr_sum       = 8'h00;
          fr_hdr_match = 1'b1;
          fr_hi_nib    = 4'h0;
          fr_hi_ok     = 1'b1;
        end
      end
      nsc_pkg::PH_COLLECT: begin
        if (fr_count >= nsc_pkg::HDR_FIRST && fr_count <= nsc_pkg::HDR_LAST) begin
          want = tag_now[8 * int'(nsc_pkg::HDR_LAST - fr_count) +: 8];
          if (b != want) fr_hdr_match = 1'b0;
        end
        fr_count = fr_count + 7'd1;
        if (b != nsc_pkg::CH_STAR) fr_sum = fr_sum ^ b;
        if (b == nsc_pkg::CH_STAR || fr_count >= 7'(MAX_LEN)) fr_phase = nsc_pkg::PH_HEX_HI;
      end
      nsc_pkg::PH_HEX_HI: begin
        fr_hi_nib = d[3:0];
        fr_hi_ok  = d[4];
        fr_phase  = nsc_pkg::PH_HEX_LO;
      end
      default: begin
        recv = {fr_hi_nib, d[3:0]};
        ck = fr_hi_ok & d[4] & (recv == fr_sum);
        hd = fr_hdr_match & (fr_count >= nsc_pkg::HDR_FULL);
        v = '{ck & hd, ck, hd, fr_sum, recv, fr_count};
        fr_phase = nsc_pkg::PH_HUNT;
        emit = 1'b1;
      end
    endcase
    return emit;
  endfunction

  // Offer one byte after a random gap, then update the model once it is taken
  task automatic send_rx(input logic [nsc_pkg::BYTE_W-1:0] b, input logic typed,
                         input nsc_pkg::verdict_t want);
    int unsigned       gap;
    nsc_pkg::verdict_t v;
    logic              emit;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    emit = predict_verdict(b, v);
    if (typed) pending_verdicts.push_back(want);
    else if (emit) pending_verdicts.push_back(v);
  endtask

  // Queue one byte sequence: noise, a broken start, a capped or a regular sentence
  task automatic plan_sequence(input logic want_cap);
    int unsigned                r, i, len, body_n;
    logic [nsc_pkg::BYTE_W-1:0] c, sum, bad;
    seq_kind_t                  kind;
    ck_kind_t                   ck;
    r = $urandom_range(0, 19);
    if (want_cap) kind = SEQ_CAP;
    else if (r < 2) kind = SEQ_NOISE;
    else if (r == 2) kind = SEQ_BROKEN;
    else if (r == 3) kind = SEQ_CAP;
    else kind = SEQ_WELL;
    sum = 8'h00;
    len = 0;
    case (kind)
      SEQ_NOISE: begin
        body_n = $urandom_range(1, 6);
        for (i = 0; i < body_n; i++) rx_plan.push_back(8'($urandom_range(0, 255)));
      end
      SEQ_BROKEN: begin
        rx_plan.push_back(nsc_pkg::CH_DOLLAR);
        body_n = $urandom_range(0, 10);
        for (i = 0; i < body_n; i++) rx_plan.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        // lead-in junk that cannot open a sentence
        body_n = $urandom_range(0, 2);
        for (i = 0; i < body_n; i++) begin
          c = 8'($urandom_range(0, 255));
          if (c == nsc_pkg::CH_DOLLAR) c = 8'h0A;
          rx_plan.push_back(c);
        end
        rx_plan.push_back(nsc_pkg::CH_DOLLAR);
        // mostly the configured tag, sometimes with bytes corrupted
        if (kind == SEQ_CAP || $urandom_range(0, 3) != 0) begin
          for (i = 0; i < 5; i++) begin
            c = tag_now[8 * (4 - i) +: 8];
            if ($urandom_range(0, 7) == 0) c = c ^ 8'($urandom_range(1, 255));
            rx_plan.push_back(c);
            sum = sum ^ c;
          end
          len = 5;
        end else begin
          len = $urandom_range(0, 5);
          for (i = 0; i < len; i++) begin
            c = 8'($urandom_range(32, 126));
            if (c == nsc_pkg::CH_STAR) c = 8'h2B;
            rx_plan.push_back(c);
            sum = sum ^ c;
          end
        end
        // body; a capped sentence fills up to the length cap with no star
        body_n = (kind == SEQ_CAP) ? MAX_LEN - 1 - len : $urandom_range(0, 20);
        for (i = 0; i < body_n; i++) begin
          c = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(32, 126))
                                          : 8'($urandom_range(0, 255));
          if (c == nsc_pkg::CH_STAR) c = 8'h2B;
          rx_plan.push_back(c);
          sum = sum ^ c;
        end
        if (kind != SEQ_CAP) rx_plan.push_back(nsc_pkg::CH_STAR);
        r = $urandom_range(0, 7);
        ck = (r < 6) ? CK_GOOD : (r == 6) ? CK_WRONG : CK_JUNK;
        if (ck == CK_JUNK) begin
          rx_plan.push_back(8'($urandom_range(0, 255)));
          rx_plan.push_back(8'($urandom_range(0, 255)));
        end else begin
          bad = (ck == CK_WRONG) ? 8'($urandom_range(1, 255)) : 8'h00;
          c = sum ^ bad;
          rx_plan.push_back(hex_char(c[7:4], 1'($urandom_range(0, 1))));
          rx_plan.push_back(hex_char(c[3:0], 1'($urandom_range(0, 1))));
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Compare every verdict taken with the oldest one predicted
  always @(posedge clk) begin : verdict_check
    nsc_pkg::verdict_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: unexpected verdict, expected none, actual len %0d sum %0h", $time,
                   out_ch.sentence_length, out_ch.computed_sum);
      end else begin
        want = pending_verdicts.pop_front();
        check_field("sentence_ok", 8'(want.sentence_ok), 8'(out_ch.sentence_ok));
        check_field("checksum_ok", 8'(want.checksum_ok), 8'(out_ch.checksum_ok));
        check_field("header_ok", 8'(want.header_ok), 8'(out_ch.header_ok));
        check_field("computed_sum", want.computed_sum, out_ch.computed_sum);
        check_field("received_sum", want.received_sum, out_ch.received_sum);
        check_field("sentence_length", 8'(want.sentence_length), 8'(out_ch.sentence_length));
      end
    end
  end

  // End the run when no handshake of any kind happens for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Verdict receiver: random stalls, plus one long hold-off on request
  initial begin : verdict_sink
    int unsigned wait_n;
    out_ch.ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      wait_n = no_idle ? 0 : $urandom_range(0, 9);
      if (wait_n != 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin : stimulus
    int                        p;
    int unsigned               n;
    logic [63:0]               r64;
    logic [nsc_pkg::TAG_W-1:0] tag_pick;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.rx_byte     = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.header_tag = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // walk the directed table under the reset tag
    for (int i = 0; i < 24; i++) send_rx(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].want);

    for (p = 0; p < 6; p++) begin
      in_ch.valid <= 1'b0;
      case (p)
        0: tag_pick = '0;
        1: tag_pick = '1;
        3: tag_pick = TAG_GPRMC;
        5: tag_pick = nsc_pkg::TAG_RESET;
        default: begin
          r64 = {$urandom, $urandom};
          tag_pick = r64[nsc_pkg::TAG_W-1:0];
        end
      endcase
      // write the tag only once the block has drained
      while (pending_verdicts.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      cfg_ch.valid      <= 1'b1;
      cfg_ch.header_tag <= tag_pick;
      do @(posedge clk); while (!cfg_ch.ready);
      cfg_ch.valid <= 1'b0;
      tag_now = tag_pick;

      no_idle  = (p == 1 || p == 4);
      hold_req = (p == 2);
      if (p == 0 || p == 3) plan_sequence(1'b1);
      n = 0;
      while (n < PHASE_ITEMS || rx_plan.size() != 0) begin
        if (rx_plan.size() == 0) plan_sequence(1'b0);
        send_rx(rx_plan.pop_front(), 1'b0, NO_VERDICT);
        n++;
      end
    end
    in_ch.valid <= 1'b0;

    // drain, then let the pipeline settle
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
